// ===== rtl/core/dhpt_pkg.sv =====
// Package for the double hashing page table.
// Sizes, widths, command, mark and register codes used by every file but dhpt_ram.sv; no dependencies.
package dhpt_pkg;
  localparam int MAX_PAGES = 64;
  localparam int MEM_WORDS = 4096;

  localparam int CMD_W      = 3;
  localparam int PID_W      = 31;
  localparam int VA_W       = 6;
  localparam int DATA_W     = 32;
  localparam int SLOT_OUT_W = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int MARK_W     = 2;

  localparam int SLOT_W    = $clog2(MAX_PAGES);
  localparam int STEP_W    = SLOT_W + 1;
  localparam int SUM_W     = SLOT_W + 2;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REM_W     = CFG_W + 1;
  localparam int ENTRY_W   = MARK_W + PID_W;
  localparam int DIV_CNT_W = $clog2(PID_W + 1);
  localparam int A_W       = SLOT_W + CFG_W + 1;
  localparam int LA_W      = (A_W > MEM_AW + 1) ? A_W : MEM_AW + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE  = 1'b1;
endpackage

// ===== rtl/core/dhpt_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
// Depends on dhpt_pkg for field widths.
interface dhpt_in_if;
  logic                           valid;
  logic                           ready;
  logic [dhpt_pkg::CMD_W-1:0]     cmd;
  logic [dhpt_pkg::PID_W-1:0]     pid;
  logic [dhpt_pkg::VA_W-1:0]      virtual_address;
  logic signed [dhpt_pkg::DATA_W-1:0] write_data;
  modport source (output valid, cmd, pid, virtual_address, write_data, input ready);
  modport sink (input valid, cmd, pid, virtual_address, write_data, output ready);
endinterface

interface dhpt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic [dhpt_pkg::SLOT_OUT_W-1:0]     slot;
  logic signed [dhpt_pkg::DATA_W-1:0]  read_data;
  modport source (output valid, status, slot, read_data, input ready);
  modport sink (input valid, status, slot, read_data, output ready);
endinterface

// ===== rtl/core/double_hash_page_table.sv =====
// Double hashing page table: pid to slot map plus page word memory.
// Steps: modulo set-up (two 31-bit divisions, pid by the page count and then
// its quotient), then probes (up to the clamped page count), then the slot
// update or memory access; one transaction at a time. A bad command, a full
// table or an offset out of page goes straight to the response. Reset: synchronous;
// a clearing pass over all MEM_WORDS (4096) words zeroes the page memory before use.
module double_hash_page_table (
  input  logic                           clk,
  input  logic                           rst,
  dhpt_in_if.sink                        in_ch,
  dhpt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [dhpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhpt_pkg::CFG_W-1:0]     cfg_data
);
  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_DIV1  = 10'b0000000100,
    ST_DIV2  = 10'b0000001000,
    ST_PRD   = 10'b0000010000,
    ST_PCHK  = 10'b0000100000,
    ST_MUL   = 10'b0001000000,
    ST_ADDR  = 10'b0010000000,
    ST_MRD   = 10'b0100000000,
    ST_RESP  = 10'b1000000000
  } state_t;

  state_t state;

  logic [dhpt_pkg::CFG_W-1:0]  page_count;
  logic [dhpt_pkg::CFG_W-1:0]  page_size;
  logic [dhpt_pkg::CNT_W-1:0]  entry_count;
  logic [dhpt_pkg::MEM_AW-1:0] clr_cnt;
  logic                        slot_vld [dhpt_pkg::MAX_PAGES];
  logic                        vld_q;

  logic [dhpt_pkg::CMD_W-1:0]  cmd;
  logic [dhpt_pkg::PID_W-1:0]  pid;
  logic [dhpt_pkg::VA_W-1:0]   vaddr;
  logic [dhpt_pkg::DATA_W-1:0] wdata;
  logic [dhpt_pkg::CFG_W-1:0]  m;
  logic [dhpt_pkg::CFG_W-1:0]  m_eff;
  logic [dhpt_pkg::SLOT_W-1:0] pos;
  logic [dhpt_pkg::STEP_W-1:0] step;
  logic [dhpt_pkg::CFG_W-1:0]  probe_i;
  logic [dhpt_pkg::SLOT_W-1:0] free_pos;
  logic                        free_ok;
  logic [dhpt_pkg::LA_W-1:0]   addr;

  logic                            res_status;
  logic [dhpt_pkg::SLOT_OUT_W-1:0] res_slot;
  logic [dhpt_pkg::DATA_W-1:0]     res_rdata;

  logic                            out_vld;
  logic                            out_status;
  logic [dhpt_pkg::SLOT_OUT_W-1:0] out_slot;
  logic [dhpt_pkg::DATA_W-1:0]     out_rdata;

  logic                             div_start;
  logic [dhpt_pkg::PID_W-1:0]       div_dvd;
  logic                             div_done;
  logic [dhpt_pkg::PID_W-1:0]       div_quot;
  logic [dhpt_pkg::REM_W-1:0]       div_rem;

  logic                             st_we;
  logic [dhpt_pkg::SLOT_W-1:0]      st_waddr;
  logic [dhpt_pkg::ENTRY_W-1:0]     st_wdata;
  logic [dhpt_pkg::ENTRY_W-1:0]     st_rdata;
  logic [dhpt_pkg::MARK_W-1:0]      rd_mark;
  logic [dhpt_pkg::PID_W-1:0]       rd_key;

  logic                             pg_we;
  logic [dhpt_pkg::MEM_AW-1:0]      pg_waddr;
  logic [dhpt_pkg::DATA_W-1:0]      pg_wdata;
  logic [dhpt_pkg::DATA_W-1:0]      pg_rdata;

  logic                             in_acc;
  logic                             hit;
  logic                             is_empty;
  logic                             last_probe;
  logic                             cand_ok;
  logic [dhpt_pkg::SLOT_W-1:0]      cand_pos;
  logic [dhpt_pkg::SUM_W-1:0]       pos_sum;
  logic [dhpt_pkg::SLOT_W-1:0]      pos_next;
  logic                             addr_ok;
  logic                             early_fail;

  // clamp page count into 1..MAX_PAGES
  always_comb begin
    m_eff = page_count;
    if (page_count == '0) begin
      m_eff = dhpt_pkg::CFG_W'(1);
    end else if (int'(page_count) > dhpt_pkg::MAX_PAGES) begin
      m_eff = dhpt_pkg::CFG_W'(dhpt_pkg::MAX_PAGES);
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // fail without probing: bad command, full table, offset out of page
  always_comb begin
    case (in_ch.cmd)
      dhpt_pkg::CMD_INSERT: early_fail = int'(entry_count) >= int'(m_eff);
      dhpt_pkg::CMD_SEARCH: early_fail = 1'b0;
      dhpt_pkg::CMD_REMOVE: early_fail = 1'b0;
      dhpt_pkg::CMD_WRITE:  early_fail = int'(in_ch.virtual_address) >= int'(page_size);
      dhpt_pkg::CMD_READ:   early_fail = int'(in_ch.virtual_address) >= int'(page_size);
      default:              early_fail = 1'b1;
    endcase
  end

  // probe evaluation
  assign rd_mark    = vld_q ? st_rdata[dhpt_pkg::ENTRY_W-1:dhpt_pkg::PID_W]
                            : dhpt_pkg::MARK_EMPTY;
  assign rd_key     = st_rdata[dhpt_pkg::PID_W-1:0];
  assign hit        = (rd_mark == dhpt_pkg::MARK_USED) && (rd_key == pid);
  assign is_empty   = (rd_mark == dhpt_pkg::MARK_EMPTY);
  assign last_probe = (probe_i + 1'b1) == m;
  assign cand_ok    = free_ok || (rd_mark != dhpt_pkg::MARK_USED);
  assign cand_pos   = free_ok ? free_pos : pos;
  assign pos_sum    = dhpt_pkg::SUM_W'(pos) + dhpt_pkg::SUM_W'(step);
  assign pos_next   = (pos_sum >= dhpt_pkg::SUM_W'(m))
                    ? dhpt_pkg::SLOT_W'(pos_sum - dhpt_pkg::SUM_W'(m))
                    : dhpt_pkg::SLOT_W'(pos_sum);
  assign addr_ok    = addr < dhpt_pkg::LA_W'(dhpt_pkg::MEM_WORDS);

  // divider operand: pid first, then its quotient
  assign div_dvd = (state == ST_DIV1) ? div_quot : in_ch.pid;
  assign div_start = (in_acc && !early_fail) || (state == ST_DIV1 && div_done);

  // slot table update on remove hit or insert into free slot
  always_comb begin
    st_we    = 1'b0;
    st_waddr = pos;
    st_wdata = {dhpt_pkg::MARK_DELETED, dhpt_pkg::PID_W'(0)};
    if (state == ST_PCHK) begin
      if (hit && cmd == dhpt_pkg::CMD_REMOVE) begin
        st_we = 1'b1;
      end else if (!hit && (is_empty || last_probe) && cmd == dhpt_pkg::CMD_INSERT
                   && cand_ok) begin
        st_we    = 1'b1;
        st_waddr = cand_pos;
        st_wdata = {dhpt_pkg::MARK_USED, pid};
      end
    end
  end

  // page memory: clearing pass or a write transaction
  assign pg_we    = (state == ST_CLEAR) ||
                    (state == ST_ADDR && addr_ok && cmd == dhpt_pkg::CMD_WRITE);
  assign pg_waddr = (state == ST_CLEAR) ? clr_cnt : addr[dhpt_pkg::MEM_AW-1:0];
  assign pg_wdata = (state == ST_CLEAR) ? '0 : wdata;

  dhpt_divu u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (m),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  dhpt_ram #(.WIDTH(dhpt_pkg::ENTRY_W), .DEPTH(dhpt_pkg::MAX_PAGES)) u_slot_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (pos),
    .rdata (st_rdata)
  );

  dhpt_ram #(.WIDTH(dhpt_pkg::DATA_W), .DEPTH(dhpt_pkg::MEM_WORDS)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (addr[dhpt_pkg::MEM_AW-1:0]),
    .rdata (pg_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= dhpt_pkg::CFG_W'(64);
      page_size  <= dhpt_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        dhpt_pkg::REG_PAGE_COUNT: page_count <= cfg_data;
        dhpt_pkg::REG_PAGE_SIZE:  page_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot valid bits and their registered read alongside the RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dhpt_pkg::MAX_PAGES; k++) begin
        slot_vld[k] <= 1'b0;
      end
    end else if (st_we) begin
      slot_vld[st_waddr] <= 1'b1;
    end
    vld_q <= slot_vld[pos];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      entry_count <= '0;
      pos         <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == dhpt_pkg::MEM_AW'(dhpt_pkg::MEM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cmd        <= in_ch.cmd;
            pid        <= in_ch.pid;
            vaddr      <= in_ch.virtual_address;
            wdata      <= in_ch.write_data;
            m          <= m_eff;
            res_status <= 1'b1;
            res_slot   <= '0;
            res_rdata  <= '0;
            state      <= early_fail ? ST_RESP : ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            pos   <= dhpt_pkg::SLOT_W'(div_rem);
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            step    <= dhpt_pkg::STEP_W'(div_rem) + dhpt_pkg::STEP_W'(!div_rem[0]);
            probe_i <= '0;
            free_ok <= 1'b0;
            state   <= ST_PRD;
          end
        end
        ST_PRD: begin
          state <= ST_PCHK;
        end
        ST_PCHK: begin
          if (hit) begin
            case (cmd)
              dhpt_pkg::CMD_SEARCH: begin
                res_status <= 1'b0;
                res_slot   <= dhpt_pkg::SLOT_OUT_W'(pos);
                state      <= ST_RESP;
              end
              dhpt_pkg::CMD_REMOVE: begin
                res_status <= 1'b0;
                res_slot   <= dhpt_pkg::SLOT_OUT_W'(pos);
                if (entry_count != '0) begin
                  entry_count <= entry_count - 1'b1;
                end
                state <= ST_RESP;
              end
              dhpt_pkg::CMD_WRITE: state <= ST_MUL;
              dhpt_pkg::CMD_READ:  state <= ST_MUL;
              default:             state <= ST_RESP;
            endcase
          end else if (is_empty || last_probe) begin
            // pid absent: only insert can succeed
            if (cmd == dhpt_pkg::CMD_INSERT && cand_ok) begin
              res_status  <= 1'b0;
              res_slot    <= dhpt_pkg::SLOT_OUT_W'(cand_pos);
              entry_count <= entry_count + 1'b1;
            end
            state <= ST_RESP;
          end else begin
            free_ok  <= cand_ok;
            free_pos <= cand_pos;
            probe_i  <= probe_i + 1'b1;
            pos      <= pos_next;
            state    <= ST_PRD;
          end
        end
        ST_MUL: begin
          addr  <= dhpt_pkg::LA_W'(pos) * dhpt_pkg::LA_W'(page_size) + dhpt_pkg::LA_W'(vaddr);
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          if (!addr_ok) begin
            state <= ST_RESP;
          end else begin
            res_status <= 1'b0;
            res_slot   <= dhpt_pkg::SLOT_OUT_W'(pos);
            state      <= (cmd == dhpt_pkg::CMD_READ) ? ST_MRD : ST_RESP;
          end
        end
        ST_MRD: begin
          res_rdata <= pg_rdata;
          state     <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_vld || out_ch.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == ST_RESP && (!out_vld || out_ch.ready)) begin
      out_vld    <= 1'b1;
      out_status <= res_status;
      out_slot   <= res_slot;
      out_rdata  <= res_rdata;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  assign out_ch.valid     = out_vld;
  assign out_ch.status    = out_status;
  assign out_ch.slot      = out_slot;
  assign out_ch.read_data = out_rdata;
endmodule

// ===== rtl/core/dhpt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dhpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dhpt_divu.sv =====
// Restoring divider, one quotient bit per cycle, for the hash modulus.
// Depends on dhpt_pkg.
module dhpt_divu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dhpt_pkg::PID_W-1:0]  dividend,
  input  logic [dhpt_pkg::CFG_W-1:0]  divisor,
  output logic                        done,
  output logic [dhpt_pkg::PID_W-1:0]  quot,
  output logic [dhpt_pkg::REM_W-1:0]  rem
);
  logic [dhpt_pkg::PID_W-1:0]     dvd;
  logic [dhpt_pkg::REM_W-1:0]     rem_q;
  logic [dhpt_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [dhpt_pkg::REM_W-1:0]     rem_sh;
  logic                           ge;

  // shift in next dividend bit and try subtract
  assign rem_sh = {rem_q[dhpt_pkg::REM_W-2:0], dvd[dhpt_pkg::PID_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        dvd   <= dividend;
        rem_q <= '0;
      end else if (busy) begin
        rem_q <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
        dvd   <= {dvd[dhpt_pkg::PID_W-2:0], ge};
        cnt   <= cnt + 1'b1;
        if (cnt == dhpt_pkg::DIV_CNT_W'(dhpt_pkg::PID_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dvd;
  assign rem  = rem_q;
endmodule

// ===== dv/dhpt_tb_if.sv =====
// Testbench copies are not needed: the channel interfaces come from the RTL.
// This file holds a small helper interface bundling the configuration write port.
// Depends on dhpt_pkg for register index and data widths.
`timescale 1ns / 1ps
interface dhpt_cfg_if;
  logic                           we;
  logic [dhpt_pkg::CFG_IDX_W-1:0] index;
  logic [dhpt_pkg::CFG_W-1:0]     data;
endinterface

// ===== dv/testbench.sv =====
// Testbench for double_hash_page_table: drives command transactions, predicts
// each result with an in-bench model of the probe table and page memory, and
// compares results in order. Depends on dhpt_pkg, dhpt_if.sv and dhpt_tb_if.sv.
`timescale 1ns / 1ps
module testbench;
  logic clk;
  logic rst;
  dhpt_in_if  in_ch ();
  dhpt_out_if out_ch ();
  dhpt_cfg_if cfg ();

  double_hash_page_table dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
  );

  typedef struct packed {
    logic              status;
    logic [5:0]        slot;
    logic [31:0]       read_data;
  } result_t;

  // Predictor state
  logic [6:0]        pages_reg, words_reg;
  logic [30:0]       key_tab [dhpt_pkg::MAX_PAGES];
  logic [1:0]        mark_tab [dhpt_pkg::MAX_PAGES];
  logic [31:0]       mem_tab [dhpt_pkg::MEM_WORDS];
  int unsigned       live_entries;

  result_t           pending_results [$];
  int                error_count;
  int                idle_cycles;
  bit                stall_hold;
  bit                no_idle;
  logic [30:0]       pid_pool [$];

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic int unsigned active_pages();
    if (pages_reg == 0) return 1;
    if (pages_reg > dhpt_pkg::MAX_PAGES) return dhpt_pkg::MAX_PAGES;
    return pages_reg;
  endfunction

  function automatic int unsigned hop_of(logic [30:0] pid, int unsigned m);
    int unsigned s;
    s = (pid / m) % m;
    if (s[0] == 1'b0) s = s + 1;
    return s;
  endfunction

  function automatic bit locate_pid(logic [30:0] pid, output int unsigned where);
    int unsigned m, hop, pos;
    m = active_pages();
    hop = hop_of(pid, m);
    pos = pid % m;
    where = 0;
    for (int unsigned i = 0; i < m; i++) begin
      if (mark_tab[pos] == dhpt_pkg::MARK_USED && key_tab[pos] == pid) begin
        where = pos;
        return 1;
      end
      if (mark_tab[pos] == dhpt_pkg::MARK_EMPTY) return 0;
      pos = (pos + hop) % m;
    end
    return 0;
  endfunction

  function automatic bit word_index(logic [30:0] pid, logic [5:0] va,
                                    output int unsigned where, output int unsigned addr);
    longint unsigned a;
    addr = 0;
    where = 0;
    if (va >= words_reg) return 0;
    if (!locate_pid(pid, where)) return 0;
    a = longint'(where) * words_reg + va;
    if (a >= dhpt_pkg::MEM_WORDS) return 0;
    addr = 32'(a);
    return 1;
  endfunction

  // Apply one command to the predictor and return the expected result.
  function automatic result_t predict_page_op(logic [2:0] cmd, logic [30:0] pid,
                                              logic [5:0] va, logic [31:0] wd);
    result_t r;
    bit ok;
    int unsigned where, addr, m, hop, pos;
    ok = 0; where = 0; addr = 0;
    r.read_data = '0;
    case (cmd)
      dhpt_pkg::CMD_INSERT: begin
        m = active_pages();
        if (live_entries < m && !locate_pid(pid, where)) begin
          hop = hop_of(pid, m);
          pos = pid % m;
          for (int unsigned i = 0; i < m && !ok; i++) begin
            if (mark_tab[pos] != dhpt_pkg::MARK_USED) begin
              key_tab[pos] = pid;
              mark_tab[pos] = dhpt_pkg::MARK_USED;
              live_entries++;
              where = pos;
              ok = 1;
            end else pos = (pos + hop) % m;
          end
        end
      end
      dhpt_pkg::CMD_SEARCH: ok = locate_pid(pid, where);
      dhpt_pkg::CMD_WRITE: begin
        ok = word_index(pid, va, where, addr);
        if (ok) mem_tab[addr] = wd;
      end
      dhpt_pkg::CMD_READ: begin
        ok = word_index(pid, va, where, addr);
        if (ok) r.read_data = mem_tab[addr];
      end
      dhpt_pkg::CMD_REMOVE: begin
        ok = locate_pid(pid, where);
        if (ok) begin
          key_tab[where] = '0;
          mark_tab[where] = dhpt_pkg::MARK_DELETED;
          if (live_entries > 0) live_entries--;
        end
      end
      default: ok = 0;
    endcase
    r.status = !ok;
    r.slot = ok ? where[5:0] : 6'd0;
    if (!ok) r.read_data = '0;
    return r;
  endfunction

  // Send one command transaction and record its expected result.
  // Valid stays high after acceptance; idling or drain drops it.
  task automatic send_cmd(logic [2:0] cmd, logic [30:0] pid, logic [5:0] va,
                          logic [31:0] wd);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.pid <= pid;
    in_ch.virtual_address <= va;
    in_ch.write_data <= wd;
    do @(posedge clk); while (!in_ch.ready);
    pending_results = {pending_results, predict_page_op(cmd, pid, va, wd)};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [dhpt_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
    cfg.we <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    cfg.we <= 1'b0;
    if (idx == dhpt_pkg::REG_PAGE_COUNT) pages_reg = val;
    else words_reg = val;
    @(posedge clk);
  endtask

  function automatic logic [30:0] pick_pid();
    logic [30:0] p;
    if (pid_pool.size() != 0 && $urandom_range(99) < 80)
      return pid_pool[$urandom_range(pid_pool.size() - 1)];
    if ($urandom_range(3) == 0) p = 31'($urandom);
    else p = 31'($urandom_range(1, 300));
    if (p == 0) p = 1;
    if (pid_pool.size() < 48) pid_pool = {pid_pool, p};
    return p;
  endfunction

  function automatic logic [2:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return dhpt_pkg::CMD_INSERT;
    if (r < 40) return dhpt_pkg::CMD_SEARCH;
    if (r < 62) return dhpt_pkg::CMD_WRITE;
    if (r < 84) return dhpt_pkg::CMD_READ;
    if (r < 97) return dhpt_pkg::CMD_REMOVE;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic random_ops(int n);
    for (int k = 0; k < n; k++)
      send_cmd(pick_cmd(), pick_pid(), 6'($urandom_range(63)), $urandom);
  endtask

  // Directed: field extremes, each command, and the named corner cases.
  task automatic test_directed();
    send_cmd(dhpt_pkg::CMD_SEARCH, 31'd5, 6'd0, 32'd0);          // absent pid
    send_cmd(dhpt_pkg::CMD_INSERT, 31'h7FFFFFFF, 6'd0, 32'd0);
    send_cmd(dhpt_pkg::CMD_INSERT, 31'h7FFFFFFF, 6'd0, 32'd0);   // pid present
    send_cmd(dhpt_pkg::CMD_INSERT, 31'd1, 6'd0, 32'd0);
    send_cmd(dhpt_pkg::CMD_WRITE, 31'h7FFFFFFF, 6'd63, 32'h80000000);
    send_cmd(dhpt_pkg::CMD_WRITE, 31'd1, 6'd0, 32'h7FFFFFFF);
    send_cmd(dhpt_pkg::CMD_READ, 31'h7FFFFFFF, 6'd63, 32'hFFFFFFFF);
    send_cmd(dhpt_pkg::CMD_READ, 31'd1, 6'd0, 32'd0);
    send_cmd(dhpt_pkg::CMD_READ, 31'd1, 6'd1, 32'd0);            // cleared word
    send_cmd(dhpt_pkg::CMD_INSERT, 31'd65, 6'd0, 32'd0);         // collides with pid 1
    send_cmd(dhpt_pkg::CMD_REMOVE, 31'd1, 6'd0, 32'd0);
    send_cmd(dhpt_pkg::CMD_SEARCH, 31'd65, 6'd0, 32'd0);         // past tombstone
    send_cmd(dhpt_pkg::CMD_WRITE, 31'd1, 6'd3, 32'd9);           // absent pid
    send_cmd(dhpt_pkg::CMD_REMOVE, 31'd1, 6'd0, 32'd0);
    send_cmd(dhpt_pkg::CMD_INSERT, 31'd1, 6'd0, 32'd0);          // reuse tombstone
    send_cmd(3'd5, 31'd1, 6'd0, 32'd0);
    send_cmd(3'd7, 31'h55555555, 6'h2A, 32'hAAAAAAAA);
    drain();
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd10);
    send_cmd(dhpt_pkg::CMD_WRITE, 31'd1, 6'd10, 32'd1);          // offset out of page
    send_cmd(dhpt_pkg::CMD_READ, 31'd1, 6'd9, 32'd0);
    drain();
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd0);
    send_cmd(dhpt_pkg::CMD_READ, 31'd1, 6'd0, 32'd0);
    drain();
  endtask

  // Small tables, including a zero and an oversized page count.
  task automatic test_small_tables();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd0);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd1);
    send_cmd(dhpt_pkg::CMD_INSERT, 31'd3, 6'd0, 32'd0);
    send_cmd(dhpt_pkg::CMD_INSERT, 31'd4, 6'd0, 32'd0);          // table full
    send_cmd(dhpt_pkg::CMD_WRITE, 31'd3, 6'd0, 32'd77);
    send_cmd(dhpt_pkg::CMD_READ, 31'd3, 6'd0, 32'd0);
    drain();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd4);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd7);
    random_ops(120);
    drain();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd6);                   // even modulus: short cycles
    random_ops(150);
    drain();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd127);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd127);                  // addresses beyond memory
    random_ops(150);
    drain();
  endtask

  // Long receiver stall while commands keep coming.
  task automatic test_backpressure();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd16);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd64);
    stall_hold = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        stall_hold = 1'b0;
      end
      random_ops(20);
    join
    drain();
  endtask

  task automatic test_random_mix();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd1);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd64);
    random_ops(60);
    drain();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd64);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd64);
    random_ops(300);
    no_idle = 1'b1;
    random_ops(150);
    no_idle = 1'b0;
    drain();
    write_reg(dhpt_pkg::REG_PAGE_COUNT, 7'd13);
    write_reg(dhpt_pkg::REG_PAGE_SIZE, 7'd33);
    random_ops(420);
    drain();
  endtask

  // Receiver ready: random idling unless held or in the no-idle stretch.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !stall_hold && (no_idle || $urandom_range(99) >= 35);
  end

  // Compare each result transaction against the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_ch.status, out_ch.slot);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_ch.status);
          error_count++;
        end
        if (out_ch.slot !== exp_r.slot) begin
          $error("slot: expected %0d actual %0d", exp_r.slot, out_ch.slot);
          error_count++;
        end
        if (out_ch.read_data !== exp_r.read_data) begin
          $error("read_data: expected %0d actual %0d",
                 $signed(exp_r.read_data), out_ch.read_data);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.pid = '0;
    in_ch.virtual_address = '0;
    in_ch.write_data = '0;
    cfg.we = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    error_count = 0;
    idle_cycles = 0;
    stall_hold = 1'b0;
    no_idle = 1'b0;
    pages_reg = 7'd64;
    words_reg = 7'd64;
    live_entries = 0;
    for (int i = 0; i < dhpt_pkg::MAX_PAGES; i++) begin
      key_tab[i] = '0;
      mark_tab[i] = dhpt_pkg::MARK_EMPTY;
    end
    for (int i = 0; i < dhpt_pkg::MEM_WORDS; i++) mem_tab[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_tables();
    test_backpressure();
    test_random_mix();
    drain();
    repeat (300) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/dhpt_pkg.sv
rtl/core/dhpt_if.sv
rtl/core/dhpt_ram.sv
rtl/core/dhpt_divu.sv
rtl/core/double_hash_page_table.sv
dv/dhpt_tb_if.sv
dv/testbench.sv
